### hdl/phs_pkg.sv
// Shared types, codes and reset tables for the periodic housekeeping scheduler.
// Used by the channel interfaces, the report definition memory and the top level.
package phs_pkg;

    // Function codes of an input word.
    localparam logic [2:0] FUNC_TICK    = 3'd0;
    localparam logic [2:0] FUNC_ENABLE  = 3'd1;
    localparam logic [2:0] FUNC_DISABLE = 3'd2;
    localparam logic [2:0] FUNC_SET_IV  = 3'd3;
    localparam logic [2:0] FUNC_POOL_WR = 3'd4;

    // Kinds of an output word.
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_NACK  = 2'd1;
    localparam logic [1:0] KIND_HDR   = 2'd2;
    localparam logic [1:0] KIND_PARAM = 2'd3;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] report_id;
        logic [7:0]  new_interval;
        logic [7:0]  pool_index;
        logic [15:0] pool_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] out_report_id;
        logic [7:0]  out_param_id;
        logic [15:0] out_param_value;
        logic        last;
    } t_out_word;

    // One row of the report definition table.
    typedef struct packed {
        logic [15:0] rid;
        logic        en;
        logic [7:0]  intv;
        logic [7:0]  ticks;
        logic [2:0]  pcnt;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LRD,
        S_LCHK,
        S_TRD,
        S_TEVAL,
        S_THDR,
        S_TPAR,
        S_FLUSH
    } t_state;

    // Power-on contents of a report definition row.
    function automatic t_entry entry_reset(input logic [2:0] row);
        t_entry e;
        e = '0;
        case (row)
            3'd0: begin
                e.rid = 16'd0;  e.en = 1'b1; e.intv = 8'd10; e.pcnt = 3'd4;
            end
            3'd1: begin
                e.rid = 16'd10; e.en = 1'b1; e.intv = 8'd30; e.pcnt = 3'd3;
            end
            3'd2: begin
                e.rid = 16'd11; e.en = 1'b1; e.intv = 8'd60; e.pcnt = 3'd6;
            end
            default: begin
                e = '0;
            end
        endcase
        return e;
    endfunction

    // Fixed parameter id lists: report 0 holds ids 0..3, report 1 ids 4..6,
    // report 2 ids 7..12.
    function automatic logic [7:0] param_list(input logic [2:0] row, input logic [2:0] col);
        logic [7:0] p;
        p = 8'd0;
        case (row)
            3'd0: if (col < 3'd4) p = 8'(col);
            3'd1: if (col < 3'd3) p = 8'(col) + 8'd4;
            3'd2: if (col < 3'd6) p = 8'(col) + 8'd7;
            default: p = 8'd0;
        endcase
        return p;
    endfunction

endpackage

### hdl/phs_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on phs_pkg for the payload types.
interface phs_in_if;
    logic              valid;
    logic              ready;
    phs_pkg::t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface phs_out_if;
    logic               valid;
    logic               ready;
    phs_pkg::t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/phs_entry_mem.sv
// Report definition table: synchronous memory with registered read data.
// Per-row valid bits make unwritten rows read as their power-on contents (phs_pkg).
module phs_entry_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [AW-1:0]       i_rd_addr,
    output phs_pkg::t_entry     o_rd_data,
    input  logic                i_wr_en,
    input  logic [AW-1:0]       i_wr_addr,
    input  phs_pkg::t_entry     i_wr_data
);

    phs_pkg::t_entry r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    phs_pkg::t_entry  r_data;
    logic             r_data_vld;
    logic [AW-1:0]    r_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_data <= r_mem[i_rd_addr];
            r_addr <= i_rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_data_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_data_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_data_vld ? r_data : phs_pkg::entry_reset(3'(r_addr));

endmodule

### hdl/phs_pool_mem.sv
// Parameter value pool: synchronous memory with registered read data.
// Per-entry valid bits make unwritten entries read as zero after reset.
module phs_pool_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [15:0]   o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [15:0]   i_wr_data
);

    logic [15:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [15:0]      r_data;
    logic             r_data_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_data_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_data_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_data_vld ? r_data : 16'd0;

endmodule

### hdl/periodic_housekeeping_scheduler.sv
// Periodic housekeeping scheduler: one input word at a time, input ready only when idle.
// Command: the table is searched row by row (read, then check), then the result word is registered.
// Tick: each table row is read and evaluated, then each due report sends a header and its
// parameters, then the item is flushed; with the power-on parameter lists at most 16 words.
// Synchronous active-low reset restores the power-on report table and a zero pool at once
// through per-entry valid bits; there is no clearing pass.
module periodic_housekeeping_scheduler #(
    parameter int NUM_REPORTS = 8,
    parameter int MAX_PARAMS  = 7,
    parameter int POOL_DEPTH  = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    phs_in_if.sink    i_in,
    phs_out_if.source o_out
);

    localparam int IW  = (NUM_REPORTS > 1) ? $clog2(NUM_REPORTS) : 1;
    localparam int PAW = $clog2(POOL_DEPTH);

    // Sequencer state and captured command fields.
    phs_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_idx, n_idx;
    logic [15:0]     r_rid, n_rid;
    logic [2:0]      r_func, n_func;
    logic [7:0]      r_niv, n_niv;
    logic [2:0]      r_j, n_j;
    logic [2:0]      r_cnt, n_cnt;
    logic [15:0]     r_hdr_id, n_hdr_id;

    // Result path: a pending word held back until we know whether it is the
    // last one of the item, then the output register.
    phs_pkg::t_out_word r_pend, n_pend;
    logic               r_pend_vld, n_pend_vld;
    phs_pkg::t_out_word r_out, n_out;
    logic               r_out_vld, n_out_vld;

    // Memory ports.
    logic             ent_rd_en;
    phs_pkg::t_entry  ent;
    logic             ent_wr_en;
    phs_pkg::t_entry  ent_wr_data;
    logic             pool_rd_en;
    logic [PAW-1:0]   pool_rd_addr;
    logic [15:0]      pool_rd_data;
    logic             pool_wr_en;

    // Control decodes.
    logic               accept;
    logic               out_free;
    logic               can_push;
    logic               last_idx;
    logic [7:0]         ticks_inc;
    logic               due;
    logic               id_match;
    logic [2:0]         cnt_cap;
    logic [7:0]         cur_pid;
    logic [7:0]         nxt_pid;
    logic               cur_in_pool;
    logic               idx_in_pool;
    logic               push_en;
    phs_pkg::t_out_word push_word;
    logic               flush;

    phs_entry_mem #(
        .DEPTH (NUM_REPORTS),
        .AW    (IW)
    ) u_entry_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (ent_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (ent),
        .i_wr_en   (ent_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (ent_wr_data)
    );

    phs_pool_mem #(
        .DEPTH (POOL_DEPTH),
        .AW    (PAW)
    ) u_pool_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (pool_rd_en),
        .i_rd_addr (pool_rd_addr),
        .o_rd_data (pool_rd_data),
        .i_wr_en   (pool_wr_en),
        .i_wr_addr (i_in.data.pool_index[PAW-1:0]),
        .i_wr_data (i_in.data.pool_value)
    );

    assign i_in.ready  = (r_state == phs_pkg::S_IDLE);
    assign accept      = i_in.valid & i_in.ready;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    assign out_free  = !r_out_vld || o_out.ready;
    // Pushing a new word only needs room when an older word must move on.
    assign can_push  = !r_pend_vld || out_free;
    assign last_idx  = (r_idx == IW'(NUM_REPORTS - 1));
    assign ticks_inc = ent.ticks + 8'd1;
    assign due       = ent.en && (ticks_inc >= ent.intv);
    assign id_match  = (ent.rid == r_rid);
    assign cnt_cap   = (ent.pcnt > 3'(MAX_PARAMS)) ? 3'(MAX_PARAMS) : ent.pcnt;
    assign cur_pid   = phs_pkg::param_list(3'(r_idx), r_j);
    assign nxt_pid   = phs_pkg::param_list(3'(r_idx), 3'(r_j + 3'd1));
    // Parameter ids beyond the pool read as zero; pool writes there are dropped.
    assign cur_in_pool = ({1'b0, cur_pid} < 9'(POOL_DEPTH));
    assign idx_in_pool = ({1'b0, i_in.data.pool_index} < 9'(POOL_DEPTH));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            phs_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_in.data.func == phs_pkg::FUNC_TICK) begin
                        n_state = phs_pkg::S_TRD;
                    end else if (i_in.data.func == phs_pkg::FUNC_ENABLE ||
                                 i_in.data.func == phs_pkg::FUNC_DISABLE ||
                                 i_in.data.func == phs_pkg::FUNC_SET_IV) begin
                        n_state = phs_pkg::S_LRD;
                    end
                end
            end
            phs_pkg::S_LRD: begin
                n_state = phs_pkg::S_LCHK;
            end
            phs_pkg::S_LCHK: begin
                n_state = (id_match || last_idx) ? phs_pkg::S_FLUSH : phs_pkg::S_LRD;
            end
            phs_pkg::S_TRD: begin
                n_state = phs_pkg::S_TEVAL;
            end
            phs_pkg::S_TEVAL: begin
                if (due) begin
                    n_state = phs_pkg::S_THDR;
                end else begin
                    n_state = last_idx ? phs_pkg::S_FLUSH : phs_pkg::S_TRD;
                end
            end
            phs_pkg::S_THDR: begin
                if (can_push) begin
                    if (r_cnt == 3'd0) begin
                        n_state = last_idx ? phs_pkg::S_FLUSH : phs_pkg::S_TRD;
                    end else begin
                        n_state = phs_pkg::S_TPAR;
                    end
                end
            end
            phs_pkg::S_TPAR: begin
                if (can_push && (3'(r_j + 3'd1) == r_cnt)) begin
                    n_state = last_idx ? phs_pkg::S_FLUSH : phs_pkg::S_TRD;
                end
            end
            phs_pkg::S_FLUSH: begin
                if (!r_pend_vld || out_free) begin
                    n_state = phs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = phs_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: memory accesses, index updates and result words.
    always_comb begin
        ent_rd_en    = 1'b0;
        ent_wr_en    = 1'b0;
        ent_wr_data  = ent;
        pool_rd_en   = 1'b0;
        pool_rd_addr = cur_pid[PAW-1:0];
        pool_wr_en   = 1'b0;
        push_en      = 1'b0;
        push_word    = '0;
        flush        = 1'b0;
        n_idx        = r_idx;
        n_rid        = r_rid;
        n_func       = r_func;
        n_niv        = r_niv;
        n_j          = r_j;
        n_cnt        = r_cnt;
        n_hdr_id     = r_hdr_id;
        case (r_state)
            phs_pkg::S_IDLE: begin
                if (accept) begin
                    n_idx  = '0;
                    n_rid  = i_in.data.report_id;
                    n_func = i_in.data.func;
                    n_niv  = i_in.data.new_interval;
                    if (i_in.data.func == phs_pkg::FUNC_POOL_WR && idx_in_pool) begin
                        pool_wr_en = 1'b1;
                    end
                end
            end
            phs_pkg::S_LRD, phs_pkg::S_TRD: begin
                ent_rd_en = 1'b1;
            end
            phs_pkg::S_LCHK: begin
                // The pending slot is always empty here, so the answer goes straight in.
                if (id_match) begin
                    ent_wr_en = 1'b1;
                    if (r_func == phs_pkg::FUNC_SET_IV) begin
                        ent_wr_data.intv = r_niv;
                    end else begin
                        ent_wr_data.en    = (r_func == phs_pkg::FUNC_ENABLE);
                        ent_wr_data.ticks = 8'd0;
                    end
                    push_en        = 1'b1;
                    push_word.kind = phs_pkg::KIND_ACK;
                end else if (last_idx) begin
                    push_en                 = 1'b1;
                    push_word.kind          = phs_pkg::KIND_NACK;
                    push_word.out_report_id = r_rid;
                end else begin
                    n_idx = IW'(r_idx + 1'b1);
                end
            end
            phs_pkg::S_TEVAL: begin
                if (ent.en) begin
                    ent_wr_en         = 1'b1;
                    ent_wr_data.ticks = due ? 8'd0 : ticks_inc;
                end
                if (due) begin
                    n_hdr_id = ent.rid;
                    n_cnt    = cnt_cap;
                    n_j      = 3'd0;
                end else if (!last_idx) begin
                    n_idx = IW'(r_idx + 1'b1);
                end
            end
            phs_pkg::S_THDR: begin
                if (can_push) begin
                    push_en                 = 1'b1;
                    push_word.kind          = phs_pkg::KIND_HDR;
                    push_word.out_report_id = r_hdr_id;
                    if (r_cnt == 3'd0) begin
                        if (!last_idx) begin
                            n_idx = IW'(r_idx + 1'b1);
                        end
                    end else begin
                        // First parameter: r_j is zero here.
                        pool_rd_en   = 1'b1;
                        pool_rd_addr = cur_pid[PAW-1:0];
                    end
                end
            end
            phs_pkg::S_TPAR: begin
                if (can_push) begin
                    push_en                   = 1'b1;
                    push_word.kind            = phs_pkg::KIND_PARAM;
                    push_word.out_param_id    = cur_pid;
                    push_word.out_param_value = cur_in_pool ? pool_rd_data : 16'd0;
                    if (3'(r_j + 3'd1) == r_cnt) begin
                        if (!last_idx) begin
                            n_idx = IW'(r_idx + 1'b1);
                        end
                    end else begin
                        n_j          = 3'(r_j + 3'd1);
                        pool_rd_en   = 1'b1;
                        pool_rd_addr = nxt_pid[PAW-1:0];
                    end
                end
            end
            phs_pkg::S_FLUSH: begin
                flush = r_pend_vld && out_free;
            end
            default: begin
                flush = 1'b0;
            end
        endcase
    end

    // Result path. A pushed word displaces the pending one into the output
    // register without the last flag; the flush at the end of an item sends
    // the pending word with the last flag set.
    always_comb begin
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !o_out.ready;
        if (push_en) begin
            if (r_pend_vld) begin
                n_out      = r_pend;
                n_out.last = 1'b0;
                n_out_vld  = 1'b1;
            end
            n_pend     = push_word;
            n_pend_vld = 1'b1;
        end else if (flush) begin
            n_out      = r_pend;
            n_out.last = 1'b1;
            n_out_vld  = 1'b1;
            n_pend_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= phs_pkg::S_IDLE;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_rid    <= n_rid;
        r_func   <= n_func;
        r_niv    <= n_niv;
        r_j      <= n_j;
        r_cnt    <= n_cnt;
        r_hdr_id <= n_hdr_id;
        r_pend   <= n_pend;
        r_out    <= n_out;
    end

endmodule
